/* rtl/core/pcfl_pkg.sv */
// Shared codes, field widths and control types for the per-class free list stack.
package pcfl_pkg;

    localparam int OP_W     = 2;
    localparam int CLASS_W  = 8;
    localparam int HANDLE_W = 16;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH      = 2'd0,
        OP_POP_ONE   = 2'd1,
        OP_POP_RANGE = 2'd2,
        OP_BAD       = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_REJECT = 2'd2,
        ST_RSVD   = 2'd3
    } t_status;

    // Strobes into a store with one write and one registered read port.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

/* rtl/core/pcfl_in_if.sv */
// Request channel: operation, class, handle and burst limit with valid/ready.
interface pcfl_in_if import pcfl_pkg::*;;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [CLASS_W-1:0]  size_class;
    logic [HANDLE_W-1:0] object_handle;
    logic [COUNT_W-1:0]  max_count;

    modport source (output valid, operation, size_class, object_handle, max_count,
                    input ready);
    modport sink   (input valid, operation, size_class, object_handle, max_count,
                    output ready);
endinterface

/* rtl/core/pcfl_out_if.sv */
// Result channel: popped handle, last flag, running count and status with valid/ready.
interface pcfl_out_if import pcfl_pkg::*;;
    logic                valid;
    logic                ready;
    logic [HANDLE_W-1:0] popped_handle;
    logic                is_last;
    logic [COUNT_W-1:0]  taken_so_far;
    logic [STATUS_W-1:0] status;

    modport source (output valid, popped_handle, is_last, taken_so_far, status,
                    input ready);
    modport sink   (input valid, popped_handle, is_last, taken_so_far, status,
                    output ready);
endinterface

/* rtl/core/pcfl_link_mem.sv */
// Next-link memory indexed by handle; one write port, one registered read port.
module pcfl_link_mem import pcfl_pkg::*; #(
    parameter int HANDLE_BITS = 16
) (
    input  logic                   i_clk,
    input  t_mem_ctl               i_ctl,
    input  logic [HANDLE_BITS-1:0] i_wr_addr,
    input  logic [HANDLE_BITS-1:0] i_wr_data,
    input  logic [HANDLE_BITS-1:0] i_rd_addr,
    output logic [HANDLE_BITS-1:0] o_rd_data
);

    logic [HANDLE_BITS-1:0] r_mem [0:(1 << HANDLE_BITS)-1];
    logic [HANDLE_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/pcfl_head_store.sv */
// List head store: one entry per class, valid bits give empty lists after reset.
module pcfl_head_store import pcfl_pkg::*; #(
    parameter int  CLASS_COUNT = 16,
    parameter int  HANDLE_BITS = 16,
    localparam int CIDX_W      = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_mem_ctl               i_ctl,
    input  logic [CIDX_W-1:0]      i_wr_addr,
    input  logic [HANDLE_BITS-1:0] i_wr_data,
    input  logic [CIDX_W-1:0]      i_rd_addr,
    output logic [HANDLE_BITS-1:0] o_rd_data
);

    logic [HANDLE_BITS-1:0] r_mem [0:CLASS_COUNT-1];
    logic [CLASS_COUNT-1:0] r_vld;
    logic [HANDLE_BITS-1:0] r_rd_data;
    logic                   r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // never-written head reads as null
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

/* rtl/core/per_class_free_list_stack.sv */
// Per-class LIFO free lists: one head per class, shared next-link memory, pop sequencer.
// Push and status results are registered after the head read in S_HEAD; each popped handle
//   is registered in S_LINK after its link memory read, one read per handle, and a range pop
//   issues the next link read only when the previous result is taken by the sink.
// Throughput: one input in flight; ready returns the cycle after the last result transfer.
// Reset: synchronous active-low i_rst_n clears the sequencer, the output valid and the
//   head valid bits, so every list starts empty; input ready is low while reset is held;
//   the link memory is not cleared.
module per_class_free_list_stack import pcfl_pkg::*; #(
    parameter int CLASS_COUNT = 16,
    parameter int HANDLE_BITS = 16,
    parameter int MAX_BURST   = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    pcfl_in_if.sink  i_in,
    pcfl_out_if.source o_out
);

    localparam int CIDX_W = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
    localparam int CNT_W  = $clog2(MAX_BURST + 1);

    typedef enum logic [1:0] {
        S_IDLE,   // waiting for a request
        S_HEAD,   // head of the class list is on the store output
        S_LINK,   // next link of the current head is on the memory output
        S_OUT     // result held until the sink takes it
    } t_state;

    t_state                 r_state;
    t_op                    r_op;
    logic                   r_reject;
    logic [CIDX_W-1:0]      r_cls;
    logic [HANDLE_BITS-1:0] r_handle;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       r_taken;
    logic [HANDLE_BITS-1:0] r_cur;

    logic                   r_out_vld;
    logic [HANDLE_BITS-1:0] r_out_handle;
    logic                   r_out_last;
    logic [CNT_W-1:0]       r_out_taken;
    t_status                r_out_status;

    // input decode
    logic [HANDLE_W+HANDLE_BITS-1:0] w_in_ext;
    logic [HANDLE_BITS-1:0]          w_in_handle;
    logic [CNT_W-1:0]                w_in_count;
    logic                            w_in_reject;
    logic                            w_in_xfer;
    logic                            w_out_xfer;

    // store ports
    t_mem_ctl               w_head_ctl;
    t_mem_ctl               w_link_ctl;
    logic [HANDLE_BITS-1:0] w_head_wdata;
    logic [HANDLE_BITS-1:0] w_head_rdata;
    logic [HANDLE_BITS-1:0] w_link_raddr;
    logic [HANDLE_BITS-1:0] w_link_rdata;

    logic [CNT_W-1:0]       w_taken_inc;
    logic                   w_pop_last;

    logic [HANDLE_W+HANDLE_BITS-1:0] w_out_ext;
    logic [COUNT_W+CNT_W-1:0]        w_taken_ext;

    assign w_in_xfer  = i_in.valid && i_in.ready;
    assign w_out_xfer = r_out_vld && o_out.ready;

    // handle masked to HANDLE_BITS, zero-extended when wider than the field
    assign w_in_ext    = {{HANDLE_BITS{1'b0}}, i_in.object_handle};
    assign w_in_handle = w_in_ext[HANDLE_BITS-1:0];

    // pop-one takes at most one handle; range pop saturates at MAX_BURST
    always_comb begin
        if (t_op'(i_in.operation) == OP_POP_ONE) begin
            w_in_count = CNT_W'(1);
        end else if (i_in.max_count > COUNT_W'(MAX_BURST)) begin
            w_in_count = CNT_W'(MAX_BURST);
        end else begin
            w_in_count = i_in.max_count[CNT_W-1:0];
        end
    end

    always_comb begin
        w_in_reject = 1'b0;
        if ({1'b0, i_in.size_class} >= (CLASS_W+1)'(CLASS_COUNT)) begin
            w_in_reject = 1'b1;
        end
        case (t_op'(i_in.operation))
            OP_PUSH:      if (w_in_handle == '0) w_in_reject = 1'b1;
            OP_POP_RANGE: if (i_in.max_count == '0) w_in_reject = 1'b1;
            OP_BAD:       w_in_reject = 1'b1;
            default:      ;
        endcase
    end

    assign w_taken_inc = r_taken + CNT_W'(1);
    // stop at the count bound or at the end of the list
    assign w_pop_last  = (w_taken_inc == r_count) || (w_link_rdata == '0);

    // store control: head read at accept, head write on push or each pop,
    // link write on push, link read for each handle popped
    always_comb begin
        w_head_ctl   = '0;
        w_link_ctl   = '0;
        w_head_wdata = r_handle;
        w_link_raddr = r_cur;
        unique case (r_state)
            S_IDLE: begin
                w_head_ctl.rd_en = w_in_xfer;
            end
            S_HEAD: begin
                if (!r_reject) begin
                    if (r_op == OP_PUSH) begin
                        w_head_ctl.wr_en = 1'b1;
                        w_link_ctl.wr_en = 1'b1;
                    end else if (w_head_rdata != '0) begin
                        w_link_ctl.rd_en = 1'b1;
                        w_link_raddr     = w_head_rdata;
                    end
                end
            end
            S_LINK: begin
                w_head_ctl.wr_en = 1'b1;
                w_head_wdata     = w_link_rdata;
            end
            S_OUT: begin
                w_link_ctl.rd_en = w_out_xfer && !r_out_last;
            end
            default: ;
        endcase
    end

    pcfl_head_store #(
        .CLASS_COUNT (CLASS_COUNT),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_head (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_head_ctl),
        .i_wr_addr (r_cls),
        .i_wr_data (w_head_wdata),
        .i_rd_addr (i_in.size_class[CIDX_W-1:0]),
        .o_rd_data (w_head_rdata)
    );

    pcfl_link_mem #(
        .HANDLE_BITS (HANDLE_BITS)
    ) u_link (
        .i_clk     (i_clk),
        .i_ctl     (w_link_ctl),
        .i_wr_addr (r_handle),
        .i_wr_data (w_head_rdata),
        .i_rd_addr (w_link_raddr),
        .o_rd_data (w_link_rdata)
    );

    // sequencer: state, working head and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_op     <= t_op'(i_in.operation);
                        r_reject <= w_in_reject;
                        r_cls    <= i_in.size_class[CIDX_W-1:0];
                        r_handle <= w_in_handle;
                        r_count  <= w_in_count;
                        r_taken  <= '0;
                        r_state  <= S_HEAD;
                    end
                end
                S_HEAD: begin
                    r_cur        <= w_head_rdata;
                    r_out_handle <= '0;
                    r_out_last   <= 1'b1;
                    r_out_taken  <= '0;
                    if (r_reject) begin
                        r_out_status <= ST_REJECT;
                        r_out_vld    <= 1'b1;
                        r_state      <= S_OUT;
                    end else if (r_op == OP_PUSH) begin
                        r_out_status <= ST_OK;
                        r_out_vld    <= 1'b1;
                        r_state      <= S_OUT;
                    end else if (w_head_rdata == '0) begin
                        r_out_status <= ST_EMPTY;
                        r_out_vld    <= 1'b1;
                        r_state      <= S_OUT;
                    end else begin
                        r_state <= S_LINK;
                    end
                end
                S_LINK: begin
                    r_out_handle <= r_cur;
                    r_out_last   <= w_pop_last;
                    r_out_taken  <= w_taken_inc;
                    r_out_status <= ST_OK;
                    r_out_vld    <= 1'b1;
                    r_taken      <= w_taken_inc;
                    r_cur        <= w_link_rdata;
                    r_state      <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_xfer) begin
                        r_out_vld <= 1'b0;
                        r_state   <= r_out_last ? S_IDLE : S_LINK;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // no transfer is taken while reset is held
    assign i_in.ready = (r_state == S_IDLE) && i_rst_n;

    assign w_out_ext   = {{HANDLE_W{1'b0}}, r_out_handle};
    assign w_taken_ext = {{COUNT_W{1'b0}}, r_out_taken};

    assign o_out.valid         = r_out_vld;
    assign o_out.popped_handle = w_out_ext[HANDLE_W-1:0];
    assign o_out.is_last       = r_out_last;
    assign o_out.taken_so_far  = w_taken_ext[COUNT_W-1:0];
    assign o_out.status        = r_out_status;

endmodule
